>>> sv/bin_density_overflow_tracker_defines.svh
// Assertion macros for the bin density overflow tracker checker.
// Depends on nothing; expects signals named clock and reset where used.
// Included by the checker file.
`ifndef BIN_DENSITY_OVERFLOW_TRACKER_DEFINES_SVH
`define BIN_DENSITY_OVERFLOW_TRACKER_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define BDOT_ASSERT_HOLDS(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bdot check failed");

// Next-cycle implication, off while reset is high.
`define BDOT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bdot check failed");

`endif

>>> sv/bdot_pkg.sv
// Shared constants, codes and types of the bin density overflow tracker.
// Depends on nothing; used by the divider, the top level and the checker.
package bdot_pkg;

   localparam int GRID_ROWS = 64;
   localparam int GRID_COLS = 64;
   localparam int AREA_BITS = 40;

   localparam int NBINS    = GRID_ROWS * GRID_COLS;
   localparam int ROW_BITS = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int COL_BITS = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
   localparam int BIN_BITS = (NBINS > 1) ? $clog2(NBINS) : 1;

   localparam int COORD_BITS   = 20;
   localparam int DIM_BITS     = 16;
   localparam int THR_BITS     = 32;
   localparam int CNT_BITS     = 13;
   localparam int KIND_BITS    = 2;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 32;

   localparam int REQ_DATA_BITS = 4 * COORD_BITS;
   localparam int RSP_DATA_BITS = ((3 * CNT_BITS + 7) / 8) * 8;

   // bin edges go up to max(rows, cols) * bin size
   localparam int GRID_MAX  = (GRID_ROWS > GRID_COLS) ? GRID_ROWS : GRID_COLS;
   localparam int BASE_BITS = $clog2(GRID_MAX + 1) + DIM_BITS + 1;
   localparam int PROD_BITS = 2 * DIM_BITS;
   localparam int SUM_BITS  = ((AREA_BITS > PROD_BITS) ? AREA_BITS : PROD_BITS) + 1;
   localparam int DIVC_BITS = $clog2(COORD_BITS + 1);

   localparam logic [SUM_BITS-1:0] AREA_MAX =
      {{(SUM_BITS - AREA_BITS){1'b0}}, {AREA_BITS{1'b1}}};

   localparam logic [KIND_BITS-1:0] REQ_ADD_MOVABLE = 2'd0;
   localparam logic [KIND_BITS-1:0] REQ_ADD_FIXED   = 2'd1;
   localparam logic [KIND_BITS-1:0] REQ_REMOVE      = 2'd2;
   localparam logic [KIND_BITS-1:0] REQ_RESTORE     = 2'd3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_BIN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BIN_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_THRESHOLD  = 2'd2;

   localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 32'd4294836225;

   typedef struct packed {
      logic                  start;
      logic [COORD_BITS-1:0] dividend;
      logic [DIM_BITS-1:0]   divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                  done;
      logic [COORD_BITS-1:0] quot;
   } div_rsp_type;

endpackage

>>> sv/bdot_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module bdot_ram #(
   parameter int WIDTH     = 8,
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic                 re,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/bdot_div.sv
// Restoring divider, one quotient bit per cycle, for coordinate to bin index.
// Depends on bdot_pkg.
module bdot_div (
   input  logic                  clock,
   input  logic                  reset,
   input  bdot_pkg::div_cmd_type cmd,
   output bdot_pkg::div_rsp_type rsp
);
   import bdot_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVC_BITS-1:0]  cnt_ff, cnt_in;
   logic [DIM_BITS-1:0]   rem_ff, rem_in;
   logic [COORD_BITS-1:0] quo_ff, quo_in;
   logic [DIM_BITS-1:0]   dvs_ff, dvs_in;
   logic [DIM_BITS:0]     rem_sh;
   logic                  fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      rem_sh  = {rem_ff, quo_ff[COORD_BITS-1]};
      fits    = rem_sh >= {1'b0, dvs_ff};
      if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in = fits ? DIM_BITS'(rem_sh - {1'b0, dvs_ff}) : rem_sh[DIM_BITS-1:0];
         quo_in = {quo_ff[COORD_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIVC_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = DIVC_BITS'(COORD_BITS);
         rem_in  = '0;
         quo_in  = cmd.dividend;
         dvs_in  = cmd.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

endmodule

>>> sv/bin_density_overflow_tracker.sv
// Placement bin density map: a 64 x 64 grid of bins holding occupied area, with overflow
// marks against a programmable threshold. Each request transfer on req_ carries a kind in
// req_tuser and a cell rectangle in req_tdata; one result transfer on rsp_ follows with the
// bins newly overflowed, the bins cleared and the total overflowed. The rectangle edges are
// turned into bin indexes by one shared serial divider (four divisions in turn),
// then every covered bin takes a read-modify-write through the working and baseline
// memories in the states S_RD, S_MUL and S_WR; an empty rectangle goes straight to the
// result. Restore baseline sweeps the memories at one bin a cycle. After reset the block
// runs a clearing pass over both memories and holds req_tready low meanwhile; configuration
// writes are taken at any time and must come only while the block is idle. A bin size of
// zero acts as one; areas saturate at the top of their range and at zero.
module bin_density_overflow_tracker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // left_x, bottom_y, right_x, top_y from bit 0 up
   input  logic [bdot_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // req_type
   input  logic [bdot_pkg::KIND_BITS-1:0]       req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // new_overflow_count, cleared_overflow_count, total_overflow_count from bit 0 up, zero pad
   output logic [bdot_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bdot_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [bdot_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import bdot_pkg::*;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DIV   = 4'd2;
   localparam logic [3:0] S_SETUP = 4'd3;
   localparam logic [3:0] S_RD    = 4'd4;
   localparam logic [3:0] S_MUL   = 4'd5;
   localparam logic [3:0] S_WR    = 4'd6;
   localparam logic [3:0] S_COPY  = 4'd7;
   localparam logic [3:0] S_CPEND = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   localparam logic [COORD_BITS-1:0] LAST_COL = COORD_BITS'(GRID_COLS - 1);
   localparam logic [COORD_BITS-1:0] LAST_ROW = COORD_BITS'(GRID_ROWS - 1);

   // control and configuration
   logic [3:0]            state_ff, state_in;
   logic [DIM_BITS-1:0]   bw_ff, bh_ff;
   logic [THR_BITS-1:0]   thr_ff;

   // captured request
   logic [KIND_BITS-1:0]  kind_ff, kind_in;
   logic [COORD_BITS-1:0] lx_ff, lx_in, by_ff, by_in, rx_ff, rx_in, ty_ff, ty_in;

   // bin index search
   logic [COORD_BITS-1:0] quot_ff [4];
   logic [COORD_BITS-1:0] quot_in [4];
   logic [1:0]            sel_ff, sel_in;
   logic                  dbusy_ff, dbusy_in;
   div_cmd_type           div_cmd;
   div_rsp_type           div_rsp;

   // bin walk
   logic [ROW_BITS-1:0]   row_ff, row_in, r1_ff, r1_in;
   logic [COL_BITS-1:0]   col_ff, col_in, c0_ff, c0_in, c1_ff, c1_in;
   logic [BASE_BITS-1:0]  row_lo_ff, row_lo_in, col_lo_ff, col_lo_in;
   logic [BASE_BITS-1:0]  col_start_ff, col_start_in;
   logic [DIM_BITS-1:0]   w_ff, w_in, h_ff, h_in;
   logic [PROD_BITS-1:0]  prod_ff, prod_in;

   // memory sweeps
   logic [BIN_BITS-1:0]   sweep_ff, sweep_in, waddr_ff, waddr_in;
   logic                  copy_wr_ff, copy_wr_in;

   // counts and result
   logic [CNT_BITS-1:0]   added_ff, added_in, cleared_ff, cleared_in, total_ff, total_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CNT_BITS-1:0]   rsp_new_ff, rsp_new_in, rsp_clr_ff, rsp_clr_in;
   logic [CNT_BITS-1:0]   rsp_tot_ff, rsp_tot_in;

   // memory ports
   logic                  wk_we, wk_re, bl_we, bl_re;
   logic [BIN_BITS-1:0]   wk_waddr, wk_raddr, bl_waddr, bl_raddr;
   logic [AREA_BITS:0]    wk_wdata, wk_rdata;
   logic [AREA_BITS-1:0]  bl_wdata, bl_rdata;

   // datapath helpers
   logic [DIM_BITS-1:0]   bw_eff, bh_eff;
   logic                  req_xfer;
   logic [BIN_BITS-1:0]   bin_idx;
   logic [COORD_BITS-1:0] c1_clip, r1_clip;
   logic [BASE_BITS-1:0]  col_hi, row_hi, x_lo, x_hi, y_lo, y_hi;
   logic [SUM_BITS-1:0]   old_area, new_area, base_sum, sum_area;
   logic                  old_mark, new_mark;

   assign bw_eff   = (bw_ff == '0) ? DIM_BITS'(1) : bw_ff;
   assign bh_eff   = (bh_ff == '0) ? DIM_BITS'(1) : bh_ff;
   assign req_xfer = req_tvalid && req_tready;
   assign bin_idx  = BIN_BITS'(int'(row_ff) * GRID_COLS + int'(col_ff));

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   // configuration writes; an index past the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff  <= DIM_BITS'(1);
         bh_ff  <= DIM_BITS'(1);
         thr_ff <= THRESHOLD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BIN_WIDTH:  bw_ff  <= csr_data[DIM_BITS-1:0];
            CSR_BIN_HEIGHT: bh_ff  <= csr_data[DIM_BITS-1:0];
            CSR_THRESHOLD:  thr_ff <= csr_data[THR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // one divider serves all four edges: left, right - 1, bottom, top - 1
   always_comb begin
      div_cmd.start = (state_ff == S_DIV) && !dbusy_ff;
      case (sel_ff)
         2'd0:    div_cmd.dividend = lx_ff;
         2'd1:    div_cmd.dividend = rx_ff - 1'b1;
         2'd2:    div_cmd.dividend = by_ff;
         default: div_cmd.dividend = ty_ff - 1'b1;
      endcase
      div_cmd.divisor = sel_ff[1] ? bh_eff : bw_eff;
   end

   bdot_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   // clip the far edges to the grid
   assign c1_clip = (quot_ff[1] > LAST_COL) ? LAST_COL : quot_ff[1];
   assign r1_clip = (quot_ff[3] > LAST_ROW) ? LAST_ROW : quot_ff[3];

   // overlap of the current bin with the rectangle
   assign col_hi = col_lo_ff + BASE_BITS'(bw_eff);
   assign row_hi = row_lo_ff + BASE_BITS'(bh_eff);
   assign x_hi   = (col_hi < BASE_BITS'(rx_ff)) ? col_hi : BASE_BITS'(rx_ff);
   assign x_lo   = (col_lo_ff > BASE_BITS'(lx_ff)) ? col_lo_ff : BASE_BITS'(lx_ff);
   assign y_hi   = (row_hi < BASE_BITS'(ty_ff)) ? row_hi : BASE_BITS'(ty_ff);
   assign y_lo   = (row_lo_ff > BASE_BITS'(by_ff)) ? row_lo_ff : BASE_BITS'(by_ff);

   // read-modify-write of one bin: saturate, then compare with the threshold
   always_comb begin
      old_mark = wk_rdata[AREA_BITS];
      old_area = SUM_BITS'(wk_rdata[AREA_BITS-1:0]);
      sum_area = old_area + SUM_BITS'(prod_ff);
      base_sum = SUM_BITS'(bl_rdata) + SUM_BITS'(prod_ff);
      if (kind_ff == REQ_REMOVE) begin
         new_area = (SUM_BITS'(prod_ff) >= old_area) ? '0 : old_area - SUM_BITS'(prod_ff);
         new_mark = old_mark && (new_area > SUM_BITS'(thr_ff));
      end else begin
         new_area = (sum_area > AREA_MAX) ? AREA_MAX : sum_area;
         new_mark = old_mark || (new_area > SUM_BITS'(thr_ff));
      end
      if (base_sum > AREA_MAX) begin
         base_sum = AREA_MAX;
      end
   end

   // memory port steering
   always_comb begin
      wk_we    = 1'b0;
      wk_waddr = bin_idx;
      wk_wdata = {1'b0, new_area[AREA_BITS-1:0]};
      wk_re    = 1'b0;
      wk_raddr = bin_idx;
      bl_we    = 1'b0;
      bl_waddr = bin_idx;
      bl_wdata = base_sum[AREA_BITS-1:0];
      bl_re    = 1'b0;
      bl_raddr = bin_idx;
      unique case (state_ff) inside
         S_CLEAR: begin
            wk_we    = 1'b1;
            wk_waddr = sweep_ff;
            wk_wdata = '0;
            bl_we    = 1'b1;
            bl_waddr = sweep_ff;
            bl_wdata = '0;
         end
         S_RD: begin
            wk_re = 1'b1;
            bl_re = 1'b1;
         end
         S_WR: begin
            wk_we    = 1'b1;
            wk_wdata = {new_mark, new_area[AREA_BITS-1:0]};
            bl_we    = (kind_ff == REQ_ADD_FIXED);
         end
         S_COPY, S_CPEND: begin
            // read one bin ahead, write back the baseline with the mark dropped
            bl_re    = (state_ff == S_COPY);
            bl_raddr = sweep_ff;
            wk_we    = copy_wr_ff;
            wk_waddr = waddr_ff;
            wk_wdata = {1'b0, bl_rdata};
         end
         default: ;
      endcase
   end

   bdot_ram #(.WIDTH(AREA_BITS + 1), .DEPTH(NBINS)) u_working (
      .clock (clock),
      .we    (wk_we),
      .waddr (wk_waddr),
      .wdata (wk_wdata),
      .re    (wk_re),
      .raddr (wk_raddr),
      .rdata (wk_rdata)
   );

   bdot_ram #(.WIDTH(AREA_BITS), .DEPTH(NBINS)) u_baseline (
      .clock (clock),
      .we    (bl_we),
      .waddr (bl_waddr),
      .wdata (bl_wdata),
      .re    (bl_re),
      .raddr (bl_raddr),
      .rdata (bl_rdata)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      lx_in        = lx_ff;
      by_in        = by_ff;
      rx_in        = rx_ff;
      ty_in        = ty_ff;
      quot_in      = quot_ff;
      sel_in       = sel_ff;
      dbusy_in     = dbusy_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      r1_in        = r1_ff;
      c0_in        = c0_ff;
      c1_in        = c1_ff;
      row_lo_in    = row_lo_ff;
      col_lo_in    = col_lo_ff;
      col_start_in = col_start_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      prod_in      = prod_ff;
      sweep_in     = sweep_ff;
      waddr_in     = waddr_ff;
      copy_wr_in   = copy_wr_ff;
      added_in     = added_ff;
      cleared_in   = cleared_ff;
      total_in     = total_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_clr_in   = rsp_clr_ff;
      rsp_tot_in   = rsp_tot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         S_CLEAR: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == BIN_BITS'(NBINS - 1)) begin
               sweep_in = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               kind_in    = req_tuser;
               lx_in      = req_tdata[COORD_BITS-1:0];
               by_in      = req_tdata[2*COORD_BITS-1:COORD_BITS];
               rx_in      = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
               ty_in      = req_tdata[4*COORD_BITS-1:3*COORD_BITS];
               added_in   = '0;
               cleared_in = '0;
               sel_in     = '0;
               dbusy_in   = 1'b0;
               if (req_tuser == REQ_RESTORE) begin
                  cleared_in = total_ff;
                  total_in   = '0;
                  sweep_in   = '0;
                  copy_wr_in = 1'b0;
                  state_in   = S_COPY;
               end else if (req_tdata[3*COORD_BITS-1:2*COORD_BITS] >
                            req_tdata[COORD_BITS-1:0] &&
                            req_tdata[4*COORD_BITS-1:3*COORD_BITS] >
                            req_tdata[2*COORD_BITS-1:COORD_BITS]) begin
                  state_in = S_DIV;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_DIV: begin
            if (div_cmd.start) begin
               dbusy_in = 1'b1;
            end
            if (div_rsp.done) begin
               quot_in[sel_ff] = div_rsp.quot;
               dbusy_in        = 1'b0;
               sel_in          = sel_ff + 1'b1;
               if (sel_ff == 2'd3) begin
                  state_in = S_SETUP;
               end
            end
         end
         S_SETUP: begin
            if (quot_ff[0] > c1_clip || quot_ff[2] > r1_clip) begin
               // rectangle lies wholly past the grid
               state_in = S_DONE;
            end else begin
               row_in       = ROW_BITS'(quot_ff[2]);
               r1_in        = ROW_BITS'(r1_clip);
               col_in       = COL_BITS'(quot_ff[0]);
               c0_in        = COL_BITS'(quot_ff[0]);
               c1_in        = COL_BITS'(c1_clip);
               row_lo_in    = BASE_BITS'(BASE_BITS'(ROW_BITS'(quot_ff[2])) *
                                         BASE_BITS'(bh_eff));
               col_start_in = BASE_BITS'(BASE_BITS'(COL_BITS'(quot_ff[0])) *
                                         BASE_BITS'(bw_eff));
               col_lo_in    = col_start_in;
               state_in     = S_RD;
            end
         end
         S_RD: begin
            w_in     = DIM_BITS'(x_hi - x_lo);
            h_in     = DIM_BITS'(y_hi - y_lo);
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = w_ff * h_ff;
            state_in = S_WR;
         end
         S_WR: begin
            if (!old_mark && new_mark) begin
               added_in = added_ff + 1'b1;
               total_in = total_ff + 1'b1;
            end
            if (old_mark && !new_mark) begin
               cleared_in = cleared_ff + 1'b1;
               total_in   = total_ff - 1'b1;
            end
            state_in = S_RD;
            if (col_ff == c1_ff) begin
               col_in    = c0_ff;
               col_lo_in = col_start_ff;
               row_in    = row_ff + 1'b1;
               row_lo_in = row_hi;
               if (row_ff == r1_ff) begin
                  state_in = S_DONE;
               end
            end else begin
               col_in    = col_ff + 1'b1;
               col_lo_in = col_hi;
            end
         end
         S_COPY: begin
            copy_wr_in = 1'b1;
            waddr_in   = sweep_ff;
            sweep_in   = sweep_ff + 1'b1;
            if (sweep_ff == BIN_BITS'(NBINS - 1)) begin
               state_in = S_CPEND;
            end
         end
         S_CPEND: begin
            copy_wr_in = 1'b0;
            state_in   = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_new_in   = added_ff;
               rsp_clr_in   = cleared_ff;
               rsp_tot_in   = total_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         sel_ff       <= '0;
         dbusy_ff     <= 1'b0;
         copy_wr_ff   <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         sel_ff       <= sel_in;
         dbusy_ff     <= dbusy_in;
         copy_wr_ff   <= copy_wr_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      lx_ff        <= lx_in;
      by_ff        <= by_in;
      rx_ff        <= rx_in;
      ty_ff        <= ty_in;
      quot_ff      <= quot_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      r1_ff        <= r1_in;
      c0_ff        <= c0_in;
      c1_ff        <= c1_in;
      row_lo_ff    <= row_lo_in;
      col_lo_ff    <= col_lo_in;
      col_start_ff <= col_start_in;
      w_ff         <= w_in;
      h_ff         <= h_in;
      prod_ff      <= prod_in;
      waddr_ff     <= waddr_in;
      added_ff     <= added_in;
      cleared_ff   <= cleared_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_clr_ff   <= rsp_clr_in;
      rsp_tot_ff   <= rsp_tot_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - 3 * CNT_BITS){1'b0}},
                        rsp_tot_ff, rsp_clr_ff, rsp_new_ff};

endmodule

>>> sv/bdot_chk.sv
// Port-level checker for the bin density overflow tracker, bound to the top level.
// Depends on bdot_pkg and bin_density_overflow_tracker_defines.svh.
`include "bin_density_overflow_tracker_defines.svh"

module bdot_chk (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic [bdot_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input logic [bdot_pkg::KIND_BITS-1:0]       req_tuser,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [bdot_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input logic                                 csr_valid,
   input logic                                 csr_ready,
   input logic [bdot_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input logic [bdot_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import bdot_pkg::*;

   logic [CNT_BITS-1:0] new_cnt, clr_cnt, tot_cnt;

   assign new_cnt = rsp_tdata[CNT_BITS-1:0];
   assign clr_cnt = rsp_tdata[2*CNT_BITS-1:CNT_BITS];
   assign tot_cnt = rsp_tdata[3*CNT_BITS-1:2*CNT_BITS];

   // a stalled result holds
   `BDOT_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // adding never clears and removing never sets, restore sets nothing
   `BDOT_ASSERT_HOLDS(a_one_direction, rsp_tvalid, new_cnt == '0 || clr_cnt == '0)
   // the total never exceeds the grid
   `BDOT_ASSERT_HOLDS(a_total_bound, rsp_tvalid, tot_cnt <= CNT_BITS'(NBINS))
   // the clearing pass keeps requests out right after reset
   `BDOT_ASSERT_HOLDS(a_clear_pass, $past(reset), !req_tready)

endmodule

bind bin_density_overflow_tracker bdot_chk u_bdot_chk (.*);
